// ===== hw/rtl/qgt_pkg.sv =====
// ----------------------------------------------------------------------------
// qgt_pkg
// Shared types and constants of the 2x2 uint8 GEMM tile unit: the tile of
// accumulators, the configuration bundle, register indexes and back-end states.
// ----------------------------------------------------------------------------
package qgt_pkg;

    localparam int ACC_W     = 32;
    localparam int NUM_ACC   = 4;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int Q31_BITS  = 31;

    localparam logic [63:0] Q31_ROUND = 64'h0000_0000_4000_0000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZP   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_MULT  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_MASK  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SHIFT = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_THR   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH  = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OFFSET  = 8'd7;

    // accumulators ordered r0c0, r0c1, r1c0, r1c1
    typedef logic [NUM_ACC-1:0][ACC_W-1:0] tile_t;

    typedef struct packed {
        logic [7:0]        weight_zero_point;
        logic [30:0]       scale_multiplier;
        logic [30:0]       round_mask;
        logic [4:0]        right_shift;
        logic [30:0]       round_threshold;
        logic signed [8:0] clamp_low;
        logic signed [8:0] clamp_high;
        logic [7:0]        output_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        weight_zero_point: 8'd0,
        scale_multiplier:  31'h4000_0000,
        round_mask:        31'd0,
        right_shift:       5'd0,
        round_threshold:   31'd0,
        clamp_low:         9'sd0,
        clamp_high:        9'sd255,
        output_offset:     8'd0
    };

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_RND,
        BK_SHF,
        BK_CLP,
        BK_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/qgt_front.sv =====
// ----------------------------------------------------------------------------
// qgt_front
// Input side: accepts inner-dimension steps, runs the four MACs and pushes
// the finished accumulator tile into the queue on the last step.
// ----------------------------------------------------------------------------
module qgt_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qgt_pkg::cfg_t         cfg,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_first_step,
    input  logic                  s_last_step,
    input  logic [7:0]            s_a_row0,
    input  logic [7:0]            s_a_row1,
    input  logic [7:0]            s_b_col0,
    input  logic [7:0]            s_b_col1,
    input  logic signed [31:0]    s_bias_col0,
    input  logic signed [31:0]    s_bias_col1,
    input  logic                  q_full,
    output logic                  q_push,
    output qgt_pkg::tile_t        q_push_data
);
    import qgt_pkg::*;

    tile_t             acc_reg;
    tile_t             acc_next;
    tile_t             base;
    logic signed [8:0] w0;
    logic signed [8:0] w1;
    logic [7:0]        a_sel [NUM_ACC];
    logic signed [8:0] w_sel [NUM_ACC];
    logic signed [17:0] prod [NUM_ACC];
    logic              accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign w0 = $signed({1'b0, s_b_col0}) - $signed({1'b0, cfg.weight_zero_point});
    assign w1 = $signed({1'b0, s_b_col1}) - $signed({1'b0, cfg.weight_zero_point});

    always_comb begin
        a_sel[0] = s_a_row0;  w_sel[0] = w0;
        a_sel[1] = s_a_row0;  w_sel[1] = w1;
        a_sel[2] = s_a_row1;  w_sel[2] = w0;
        a_sel[3] = s_a_row1;  w_sel[3] = w1;
        if (s_first_step) begin
            base = {s_bias_col1, s_bias_col0, s_bias_col1, s_bias_col0};
        end else begin
            base = acc_reg;
        end
        for (int i = 0; i < NUM_ACC; i++) begin
            prod[i]     = $signed({1'b0, a_sel[i]}) * w_sel[i];
            acc_next[i] = base[i] + {{(ACC_W-18){prod[i][17]}}, prod[i]};
        end
    end

    assign q_push      = accept && s_last_step;
    assign q_push_data = acc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (accept) begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== hw/rtl/qgt_queue.sv =====
// ----------------------------------------------------------------------------
// qgt_queue
// Short FIFO of finished accumulator tiles between the MAC front end and
// the requantization back end.
// ----------------------------------------------------------------------------
module qgt_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  qgt_pkg::tile_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output qgt_pkg::tile_t head_data
);
    import qgt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tile_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hw/rtl/qgt_back.sv =====
// ----------------------------------------------------------------------------
// qgt_back
// Requantization engine: walks the four accumulators of the head tile through
// one shared Q31 multiplier and a rounding, shift and clamp path, then holds
// the four bytes in an output register until the result is taken.
// ----------------------------------------------------------------------------
module qgt_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  qgt_pkg::cfg_t  cfg,
    input  logic           head_valid,
    input  qgt_pkg::tile_t head_data,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_r0c0,
    output logic [7:0]     m_out_r0c1,
    output logic [7:0]     m_out_r1c0,
    output logic [7:0]     m_out_r1c1
);
    import qgt_pkg::*;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [1:0]          idx_reg;
    logic [1:0]          idx_next;
    logic signed [63:0]  prod_reg;
    logic [31:0]         q_reg;
    logic signed [32:0]  rnd_reg;
    logic [3:0][7:0]     out_reg;

    logic                ld_mul;
    logic                ld_rnd;
    logic                ld_shf;
    logic                ld_clp;

    logic [63:0]         rsum;
    logic                neg;
    logic signed [32:0]  rem;
    logic                round_up;
    logic signed [31:0]  shifted;
    logic signed [32:0]  lo;
    logic signed [32:0]  hi;
    logic signed [32:0]  clamped;
    logic [7:0]          out_byte;

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            BK_IDLE: begin
                idx_next = '0;
                if (head_valid) begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL: state_next = BK_RND;
            BK_RND: state_next = BK_SHF;
            BK_SHF: state_next = BK_CLP;
            BK_CLP: begin
                if (idx_reg == 2'd3) begin
                    state_next = BK_OUT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = BK_MUL;
                end
            end
            BK_OUT: begin
                if (m_ready) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs and load enables
    always_comb begin
        ld_mul  = 1'b0;
        ld_rnd  = 1'b0;
        ld_shf  = 1'b0;
        ld_clp  = 1'b0;
        m_valid = 1'b0;
        pop     = 1'b0;
        case (state_reg)
            BK_MUL: ld_mul = 1'b1;
            BK_RND: ld_rnd = 1'b1;
            BK_SHF: ld_shf = 1'b1;
            BK_CLP: ld_clp = 1'b1;
            BK_OUT: begin
                m_valid = 1'b1;
                pop     = m_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // round at bit 30 and keep bits 62..31
    assign rsum = prod_reg + Q31_ROUND;

    // remainder-threshold rounding of the arithmetic shift
    assign neg      = q_reg[31];
    assign rem      = $signed({2'b00, q_reg[30:0] & cfg.round_mask}) - $signed({32'd0, neg});
    assign round_up = rem > $signed({2'b00, cfg.round_threshold});
    assign shifted  = $signed(q_reg) >>> cfg.right_shift;

    // clamp to low, then high, so inverted bounds give clamp_high
    assign lo = {{24{cfg.clamp_low[8]}}, cfg.clamp_low};
    assign hi = {{24{cfg.clamp_high[8]}}, cfg.clamp_high};

    always_comb begin
        clamped = rnd_reg;
        if (clamped < lo) begin
            clamped = lo;
        end
        if (clamped > hi) begin
            clamped = hi;
        end
        out_byte = clamped[7:0] + cfg.output_offset;
    end

    always_ff @(posedge aclk) begin
        if (ld_mul) begin
            prod_reg <= $signed(head_data[idx_reg]) * $signed({1'b0, cfg.scale_multiplier});
        end
        if (ld_rnd) begin
            q_reg <= rsum[62:Q31_BITS];
        end
        if (ld_shf) begin
            rnd_reg <= {shifted[31], shifted} + $signed({32'd0, round_up});
        end
        if (ld_clp) begin
            out_reg[idx_reg] <= out_byte;
        end
    end

    assign m_out_r0c0 = out_reg[0];
    assign m_out_r0c1 = out_reg[1];
    assign m_out_r1c0 = out_reg[2];
    assign m_out_r1c1 = out_reg[3];

endmodule

// ===== hw/rtl/quantized_gemm_tile_2x2_unit.sv =====
// ----------------------------------------------------------------------------
// quantized_gemm_tile_2x2_unit
// 2x2 uint8 GEMM tile with Q31 fixed-point requantization to bytes.
// ----------------------------------------------------------------------------
// The front end takes one inner-dimension step per cycle while the queue is
// not full (four 8x9-bit MACs into 32-bit wrapping accumulators). On the last
// step the tile is handed to a queue of QUEUE_DEPTH entries; the front only
// stalls when that queue is full. The back end requantizes the four
// accumulators one after another through a single 32x31 multiplier, each in
// the multiply, round, shift and clamp states, and then presents the result
// from the output register; it goes back to idle after the result is taken.
// Tiles of 18 or more steps stream without stalls while m_ready stays high.
// Configuration (cfg_ready is always high) must be written while no tile is
// in flight.
module quantized_gemm_tile_2x2_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qgt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qgt_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_first_step,
    input  logic                            s_last_step,
    input  logic [7:0]                      s_a_row0,
    input  logic [7:0]                      s_a_row1,
    input  logic [7:0]                      s_b_col0,
    input  logic [7:0]                      s_b_col1,
    input  logic signed [31:0]              s_bias_col0,
    input  logic signed [31:0]              s_bias_col1,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_out_r0c0,
    output logic [7:0]                      m_out_r0c1,
    output logic [7:0]                      m_out_r1c0,
    output logic [7:0]                      m_out_r1c1
);
    import qgt_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_full;
    logic  q_push;
    tile_t q_push_data;
    logic  q_pop;
    logic  q_head_valid;
    tile_t q_head_data;

    assign cfg_ready = 1'b1;

    // register file: out-of-range indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_WEIGHT_ZP:   cfg_next.weight_zero_point = cfg_data[7:0];
                REG_SCALE_MULT:  cfg_next.scale_multiplier  = cfg_data[30:0];
                REG_ROUND_MASK:  cfg_next.round_mask        = cfg_data[30:0];
                REG_RIGHT_SHIFT: cfg_next.right_shift       = cfg_data[4:0];
                REG_ROUND_THR:   cfg_next.round_threshold   = cfg_data[30:0];
                REG_CLAMP_LOW:   cfg_next.clamp_low         = $signed(cfg_data[8:0]);
                REG_CLAMP_HIGH:  cfg_next.clamp_high        = $signed(cfg_data[8:0]);
                REG_OUT_OFFSET:  cfg_next.output_offset     = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    qgt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_first_step(s_first_step),
        .s_last_step (s_last_step),
        .s_a_row0    (s_a_row0),
        .s_a_row1    (s_a_row1),
        .s_b_col0    (s_b_col0),
        .s_b_col1    (s_b_col1),
        .s_bias_col0 (s_bias_col0),
        .s_bias_col1 (s_bias_col1),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    qgt_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_head_valid),
        .head_data (q_head_data)
    );

    qgt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .head_valid(q_head_valid),
        .head_data (q_head_data),
        .pop       (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_r0c0(m_out_r0c0),
        .m_out_r0c1(m_out_r0c1),
        .m_out_r1c0(m_out_r1c0),
        .m_out_r1c1(m_out_r1c1)
    );

endmodule

// ===== hw/rtl/qgt_checker.sv =====
// ----------------------------------------------------------------------------
// qgt_checker
// Port-level checks of the GEMM tile unit, bound to the top level.
// ----------------------------------------------------------------------------
module qgt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_r0c0,
    input logic [7:0] m_out_r0c1,
    input logic [7:0] m_out_r1c0,
    input logic [7:0] m_out_r1c1
);

    // a pending result holds until taken
    a_m_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before the transaction completed");

    a_m_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_out_r0c0, m_out_r0c1, m_out_r1c0, m_out_r1c1}))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // the back end returns to idle after each result, so results never come back to back
    a_result_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("results issued in consecutive cycles");

endmodule

bind quantized_gemm_tile_2x2_unit qgt_checker u_qgt_checker (.*);
